@@ hw/rtl/aug_pkg.sv @@
// ----------------------------------------------------------------------------
// aug_pkg
// Types and constants for the angle unwrap and glitch filter block.
// ----------------------------------------------------------------------------
package aug_pkg;

   localparam int AngleWidth  = 12;
   localparam int AccumWidth  = 32;
   localparam int OutAccWidth = 32;
   localparam int MissWidth   = 8;
   localparam int StepWidth   = AngleWidth + 1;
   localparam int CsrIdxWidth = 4;
   localparam int CsrDataWidth = 12;

   localparam logic signed [StepWidth-1:0] HalfTurn = StepWidth'(2048);
   localparam logic signed [StepWidth-1:0] FullTurn = StepWidth'(4096);
   localparam logic [MissWidth-1:0]        MissMax  = '1;

   localparam logic [AngleWidth-1:0] GlitchLimitReset = AngleWidth'(512);
   localparam logic [MissWidth-1:0]  MissLimitReset   = MissWidth'(30);

   typedef enum logic {
      OP_SAMPLE   = 1'b0,
      OP_SET_ZERO = 1'b1
   } op_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_GLITCH_LIMIT = 4'd0,
      REG_MISS_LIMIT   = 4'd1
   } reg_idx_type;

   typedef struct packed {
      logic [AngleWidth-1:0]        zero_offset;
      logic [AngleWidth-1:0]        last_good_raw;
      logic [AngleWidth-1:0]        previous_angle;
      logic                         first_sample;
      logic signed [AccumWidth-1:0] accumulated_angle;
      logic [MissWidth-1:0]         miss_counter;
      logic                         link_up;
   } track_state_type;

   typedef struct packed {
      logic [AngleWidth-1:0]         angle;
      logic signed [OutAccWidth-1:0] continuous_angle;
      logic                          glitch;
      logic                          connected;
   } result_type;

   typedef struct packed {
      logic [AngleWidth-1:0] glitch_limit;
      logic [MissWidth-1:0]  miss_limit;
   } cfg_type;

endpackage

@@ hw/rtl/aug_if.sv @@
// ----------------------------------------------------------------------------
// aug_if
// Channel interfaces: sample requests, results and register writes.
// ----------------------------------------------------------------------------
interface aug_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic                             read_ok;
   logic [aug_pkg::AngleWidth-1:0]   raw_angle;

   modport source (output valid, opcode, read_ok, raw_angle, input ready);
   modport sink   (input valid, opcode, read_ok, raw_angle, output ready);
endinterface

interface aug_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [aug_pkg::AngleWidth-1:0]         angle;
   logic signed [aug_pkg::OutAccWidth-1:0] continuous_angle;
   logic                                   glitch;
   logic                                   connected;

   modport source (output valid, angle, continuous_angle, glitch, connected, input ready);
   modport sink   (input valid, angle, continuous_angle, glitch, connected, output ready);
endinterface

interface aug_csr_if;
   logic                               valid;
   logic                               ready;
   logic [aug_pkg::CsrIdxWidth-1:0]    index;
   logic [aug_pkg::CsrDataWidth-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/aug_step.sv @@
// ----------------------------------------------------------------------------
// aug_step
// Per-sample update: raw selection, miss tracking, zero correction,
// shortest-step unwrap, glitch rejection and accumulation.
// ----------------------------------------------------------------------------
module aug_step (
   input  aug_pkg::track_state_type          state,
   input  aug_pkg::cfg_type                  cfg,
   input  logic                              opcode,
   input  logic                              read_ok,
   input  logic [aug_pkg::AngleWidth-1:0]    raw_angle,
   output aug_pkg::track_state_type          state_next,
   output aug_pkg::result_type               result
);

   logic [aug_pkg::AngleWidth-1:0]        raw;
   logic [aug_pkg::AngleWidth-1:0]        corrected;
   logic signed [aug_pkg::StepWidth-1:0]  diff;
   logic signed [aug_pkg::StepWidth-1:0]  step;
   logic [aug_pkg::StepWidth-1:0]         mag;
   logic                                  reject;

   always_comb begin
      raw       = read_ok ? raw_angle : state.last_good_raw;
      corrected = raw - state.zero_offset;
      diff      = $signed({1'b0, corrected}) - $signed({1'b0, state.previous_angle});
      if (diff < -aug_pkg::HalfTurn) begin
         step = diff + aug_pkg::FullTurn;
      end else if (diff > aug_pkg::HalfTurn) begin
         step = diff - aug_pkg::FullTurn;
      end else begin
         step = diff;
      end
      mag    = step[aug_pkg::StepWidth-1] ? aug_pkg::StepWidth'(-step) : step;
      reject = mag > {1'b0, cfg.glitch_limit};
   end

   always_comb begin
      state_next    = state;
      result.glitch = 1'b0;
      result.angle  = corrected;

      if (read_ok) begin
         state_next.last_good_raw = raw_angle;
         state_next.miss_counter  = '0;
         state_next.link_up       = 1'b1;
      end else begin
         if (state.miss_counter != aug_pkg::MissMax) begin
            state_next.miss_counter = state.miss_counter + 1'b1;
         end
         if (state_next.miss_counter > cfg.miss_limit) begin
            state_next.link_up = 1'b0;
         end
      end

      if (opcode == aug_pkg::OP_SET_ZERO) begin
         state_next.zero_offset       = raw;
         state_next.previous_angle    = '0;
         state_next.accumulated_angle = '0;
         state_next.first_sample      = 1'b1;
         result.angle                 = '0;
      end else if (state.first_sample) begin
         state_next.previous_angle = corrected;
         state_next.first_sample   = 1'b0;
      end else if (reject) begin
         result.glitch = 1'b1;
         result.angle  = state.previous_angle;
      end else begin
         state_next.accumulated_angle = state.accumulated_angle
                                      + aug_pkg::AccumWidth'(step);
         state_next.previous_angle    = corrected;
      end

      result.continuous_angle = aug_pkg::OutAccWidth'(state_next.accumulated_angle);
      result.connected        = state_next.link_up;
   end

endmodule

@@ hw/rtl/angle_unwrap_glitch_filter.sv @@
// ----------------------------------------------------------------------------
// angle_unwrap_glitch_filter
// Unwraps 12-bit encoder samples into a signed continuous angle, with
// missed-read tracking, zeroing and glitch rejection.
// ----------------------------------------------------------------------------
//  channel   dir   contents
//  req_if    in    opcode, read_ok, raw_angle
//  rsp_if    out   angle, continuous_angle, glitch, connected
//  csr_if    in    index, data (glitch_limit, miss_limit)
//
//  One sample per cycle unless the result stalls; its result is registered
//  and shows in the next cycle. The tracking state updates in the cycle of
//  the transfer, through one add/compare path.
//  Reset clears the tracking state and loads glitch_limit 512, miss_limit 30.
//  A stalled result holds; a new sample is taken when the result register
//  is empty or being drained.
// ----------------------------------------------------------------------------
module angle_unwrap_glitch_filter (
   input  logic          clock,
   input  logic          reset,
   aug_req_if.sink       req_if,
   aug_rsp_if.source     rsp_if,
   aug_csr_if.sink       csr_if
);

   aug_pkg::track_state_type state_ff;
   aug_pkg::track_state_type state_in;
   aug_pkg::result_type      result_ff;
   aug_pkg::result_type      result_in;
   aug_pkg::cfg_type         cfg_ff;
   aug_pkg::cfg_type         cfg_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     req_xfer;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   aug_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .opcode     (req_if.opcode),
      .read_ok    (req_if.read_ok),
      .raw_angle  (req_if.raw_angle),
      .state_next (state_in),
      .result     (result_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            aug_pkg::REG_GLITCH_LIMIT: cfg_in.glitch_limit =
               aug_pkg::AngleWidth'(csr_if.data);
            aug_pkg::REG_MISS_LIMIT:   cfg_in.miss_limit =
               aug_pkg::MissWidth'(csr_if.data);
            default: cfg_in = cfg_ff;
         endcase
      end
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glitch_limit         <= aug_pkg::GlitchLimitReset;
         cfg_ff.miss_limit           <= aug_pkg::MissLimitReset;
         state_ff.zero_offset        <= '0;
         state_ff.last_good_raw      <= '0;
         state_ff.previous_angle     <= '0;
         state_ff.first_sample       <= 1'b1;
         state_ff.accumulated_angle  <= '0;
         state_ff.miss_counter       <= '0;
         state_ff.link_up            <= 1'b0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.angle            = result_ff.angle;
   assign rsp_if.continuous_angle = result_ff.continuous_angle;
   assign rsp_if.glitch           = result_ff.glitch;
   assign rsp_if.connected        = result_ff.connected;

`ifndef ASSERT_OFF
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_if.opcode == aug_pkg::OP_SET_ZERO) |=>
         rsp_if.valid && (rsp_if.angle == '0) && (rsp_if.continuous_angle == '0)
         && !rsp_if.glitch)
      else $error("set zero did not clear the result");

   a_good_read: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_if.read_ok |=>
         rsp_if.connected && (state_ff.miss_counter == '0))
      else $error("good read did not restore link");

   a_glitch_hold: assert property (@(posedge clock) disable iff (reset)
      req_xfer && result_in.glitch |=>
         (state_ff.accumulated_angle == $past(state_ff.accumulated_angle))
         && (state_ff.previous_angle == $past(state_ff.previous_angle))
         && (rsp_if.angle == $past(state_ff.previous_angle)))
      else $error("rejected step changed tracking state");
`endif

endmodule

@@ tb/angle_track_checker.sv @@
// ----------------------------------------------------------------------------
// angle_track_checker
// Watches the sample, result and register channels. It keeps its own copy
// of the tracking state and limits, works out the result of every sample
// transfer and compares each result transfer, field by field, with the
// oldest expectation.
// ----------------------------------------------------------------------------
module angle_track_checker
   import aug_pkg::*;
(
   input  logic clock,
   input  logic reset,
   aug_req_if   req_if,
   aug_rsp_if   rsp_if,
   aug_csr_if   csr_if,
   output int   fail_count,
   output int   outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HalfTurnCounts = 2048;
   localparam int FullTurnCounts = 4096;

   track_state_type trk;
   cfg_type         limits;
   result_type      awaited_results[$];
   int              mismatches = 0;

   function automatic result_type advance_tracker(input op_type op, input logic ok,
                                                  input logic [AngleWidth-1:0] raw_in);
      result_type            res;
      logic [AngleWidth-1:0] raw;
      logic [AngleWidth-1:0] corrected;
      int                    step;
      int                    mag;
      res = '0;
      if (ok) begin
         raw = raw_in;
         trk.last_good_raw = raw_in;
         trk.miss_counter = '0;
         trk.link_up = 1'b1;
      end else begin
         raw = trk.last_good_raw;
         if (trk.miss_counter != MissMax) begin
            trk.miss_counter = trk.miss_counter + 1'b1;
         end
         if (trk.miss_counter > limits.miss_limit) begin
            trk.link_up = 1'b0;
         end
      end
      if (op == OP_SET_ZERO) begin
         trk.zero_offset = raw;
         trk.previous_angle = '0;
         trk.accumulated_angle = '0;
         trk.first_sample = 1'b1;
         res.angle = '0;
      end else begin
         corrected = raw - trk.zero_offset;
         if (trk.first_sample) begin
            trk.previous_angle = corrected;
            trk.first_sample = 1'b0;
            res.angle = corrected;
         end else begin
            step = int'(corrected) - int'(trk.previous_angle);
            if (step < -HalfTurnCounts) begin
               step = step + FullTurnCounts;
            end else if (step > HalfTurnCounts) begin
               step = step - FullTurnCounts;
            end
            mag = (step < 0) ? -step : step;
            if (mag > int'(limits.glitch_limit)) begin
               res.glitch = 1'b1;
               res.angle = trk.previous_angle;
            end else begin
               trk.accumulated_angle = trk.accumulated_angle + AccumWidth'(step);
               trk.previous_angle = corrected;
               res.angle = corrected;
            end
         end
      end
      res.continuous_angle = OutAccWidth'(trk.accumulated_angle);
      res.connected = trk.link_up;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         trk = '0;
         trk.first_sample = 1'b1;
         limits.glitch_limit = GlitchLimitReset;
         limits.miss_limit = MissLimitReset;
         awaited_results.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               REG_GLITCH_LIMIT: limits.glitch_limit = csr_if.data[AngleWidth-1:0];
               REG_MISS_LIMIT:   limits.miss_limit = csr_if.data[MissWidth-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            awaited_results.push_back(advance_tracker(op_type'(req_if.opcode),
                                                      req_if.read_ok, req_if.raw_angle));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with no sample outstanding");
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_if.angle !== want.angle) begin
                  $error("angle: expected %0d, got %0d", want.angle, rsp_if.angle);
                  mismatches++;
               end
               if (rsp_if.continuous_angle !== want.continuous_angle) begin
                  $error("continuous_angle: expected %0d, got %0d",
                         want.continuous_angle, rsp_if.continuous_angle);
                  mismatches++;
               end
               if (rsp_if.glitch !== want.glitch) begin
                  $error("glitch: expected %0d, got %0d", want.glitch, rsp_if.glitch);
                  mismatches++;
               end
               if (rsp_if.connected !== want.connected) begin
                  $error("connected: expected %0d, got %0d", want.connected, rsp_if.connected);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      outstanding <= awaited_results.size();
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives encoder samples and limit writes into the angle unwrap filter with
// random gaps and result stalls. A directed opening covers wrap, exact half
// turn, glitch limits, zeroing and missed reads; random phases follow under
// several limit settings. The checker beside the block gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import aug_pkg::*;

   localparam int ResetCycles  = 6;
   localparam int SettleCycles = 4;
   localparam int DrainCycles  = 10;
   localparam int QuietLimit   = 4000;
   localparam logic [CsrIdxWidth-1:0] RegUnmapped = 4'hF;

   logic clock = 1'b0;
   logic reset;
   logic steady;
   int   fail_count;
   int   outstanding;
   int   quiet_cycles = 0;
   logic [AngleWidth-1:0] shaft_pos = '0;

   aug_req_if req_ch ();
   aug_rsp_if rsp_ch ();
   aug_csr_if csr_ch ();

   angle_unwrap_glitch_filter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   angle_track_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_if      (csr_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input op_type op, input logic ok, input logic [AngleWidth-1:0] raw);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.read_ok   <= ok;
      req_ch.raw_angle <= raw;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_directed();
      send_item(OP_SAMPLE, 1'b0, 12'hFFF);
      send_item(OP_SAMPLE, 1'b1, 12'd0);
      send_item(OP_SAMPLE, 1'b1, 12'd4095);
      send_item(OP_SAMPLE, 1'b1, 12'd0);
      send_item(OP_SAMPLE, 1'b1, 12'd512);
      send_item(OP_SAMPLE, 1'b1, 12'd1025);
      send_item(OP_SAMPLE, 1'b1, 12'd0);
      send_item(OP_SET_ZERO, 1'b1, 12'd2048);
      send_item(OP_SAMPLE, 1'b1, 12'd2048);
      send_item(OP_SAMPLE, 1'b1, 12'd100);
      send_item(OP_SET_ZERO, 1'b0, 12'hABC);
      send_item(OP_SAMPLE, 1'b1, 12'd4095);
      write_reg(REG_GLITCH_LIMIT, 12'd2048);
      // exact half turn down, then back up
      send_item(OP_SAMPLE, 1'b1, 12'd2047);
      send_item(OP_SAMPLE, 1'b1, 12'd4095);
      write_reg(REG_MISS_LIMIT, 12'd0);
      send_item(OP_SAMPLE, 1'b0, 12'h555);
      send_item(OP_SAMPLE, 1'b1, 12'hAAA);
      write_reg(REG_GLITCH_LIMIT, 12'd0);
      send_item(OP_SAMPLE, 1'b1, 12'hAAA);
      send_item(OP_SAMPLE, 1'b1, 12'hAAB);
      write_reg(RegUnmapped, 12'hFFF);
      send_item(OP_SAMPLE, 1'b1, 12'hAAB);
   endtask

   task automatic run_phase(input int glitch, input int miss, input int count,
                            input logic no_idle, input int miss_run);
      int kind;
      int step;
      int span;
      int burst_left;
      logic [AngleWidth-1:0] raw;
      write_reg(REG_GLITCH_LIMIT, CsrDataWidth'(glitch));
      write_reg(REG_MISS_LIMIT, CsrDataWidth'(miss));
      steady <= no_idle;
      burst_left = miss_run;
      span = (glitch == 0) ? 1 : ((glitch > 300) ? 300 : glitch);
      repeat (count + miss_run) begin
         kind = $urandom_range(0, 99);
         if (burst_left > 0) begin
            burst_left--;
            send_item(OP_SAMPLE, 1'b0, AngleWidth'($urandom_range(0, 4095)));
         end else if (kind < 65) begin
            step = $urandom_range(0, 2 * span) - span;
            shaft_pos = shaft_pos + AngleWidth'(step);
            send_item(OP_SAMPLE, 1'b1, shaft_pos);
         end else if (kind < 75) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                     : $urandom_range(0, 2);
            send_item(OP_SAMPLE, 1'b0, AngleWidth'($urandom_range(0, 4095)));
         end else if (kind < 83) begin
            send_item(OP_SAMPLE, 1'b1, AngleWidth'($urandom_range(0, 4095)));
         end else if (kind < 88) begin
            step = $urandom_range(0, 1) ? glitch : glitch + 1;
            raw = $urandom_range(0, 1) ? shaft_pos + AngleWidth'(step)
                                       : shaft_pos - AngleWidth'(step);
            if (step == glitch) shaft_pos = raw;
            send_item(OP_SAMPLE, 1'b1, raw);
         end else if (kind < 92) begin
            raw = shaft_pos + AngleWidth'(2048);
            if (glitch >= 2048) shaft_pos = raw;
            send_item(OP_SAMPLE, 1'b1, raw);
         end else if (kind < 96) begin
            if ($urandom_range(0, 3) != 0) begin
               send_item(OP_SET_ZERO, 1'b1, shaft_pos);
            end else begin
               send_item(OP_SET_ZERO, 1'b0, AngleWidth'($urandom_range(0, 4095)));
            end
         end else begin
            send_item(op_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      AngleWidth'($urandom_range(0, 4095)));
         end
      end
   endtask

   // result side stalls
   initial begin
      int run_len;
      run_len = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady) begin
            rsp_ch.ready <= 1'b1;
         end else if (run_len > 0) begin
            run_len--;
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_ch.ready <= 1'b1;
            run_len = $urandom_range(0, 20);
         end else begin
            rsp_ch.ready <= 1'b0;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("angle_unwrap_glitch_filter: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      steady           <= 1'b0;
      req_ch.valid     <= 1'b0;
      req_ch.opcode    <= OP_SAMPLE;
      req_ch.read_ok   <= 1'b0;
      req_ch.raw_angle <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= REG_GLITCH_LIMIT;
      csr_ch.data      <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_phase(GlitchLimitReset, MissLimitReset, 130, 1'b0, 0);
      run_phase(0, 0, 130, 1'b0, 0);
      // long miss run saturates the counter
      run_phase(2048, 255, 130, 1'b0, 260);
      run_phase(1, 1, 130, 1'b1, 0);
      run_phase($urandom_range(0, 2048), $urandom_range(0, 255), 130, 1'b0, 0);
      run_phase($urandom_range(0, 2048), $urandom_range(0, 255), 130, 1'b0, 0);

      req_ch.valid <= 1'b0;
      steady <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("angle_unwrap_glitch_filter: match");
      end else begin
         $display("angle_unwrap_glitch_filter: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/aug_pkg.sv
hw/rtl/aug_if.sv
hw/rtl/aug_step.sv
hw/rtl/angle_unwrap_glitch_filter.sv
tb/angle_track_checker.sv
tb/testbench.sv
